>>> sv/sfir_pkg.sv
// Shared widths, codes and controller/datapath interface types for the symmetric FIR filter.
`timescale 1ns / 1ps

package sfir_pkg;

   localparam int TAPS_DEFAULT     = 257;
   localparam int CHANNELS_DEFAULT = 2;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int INDEX_W  = 8;
   localparam int PAIR_W   = SAMPLE_W + 1;
   localparam int PROD_W   = COEF_W + PAIR_W;
   localparam int OUT_W    = 43;

   // item kind codes
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic take_sample;  // latch sample and channel of an accepted sample item
      logic take_coef;    // write a half-tap coefficient
      logic write;        // push the sample into its delay line, clear accumulator
      logic issue;        // issue one tap-pair read into the MAC pipeline
      logic load_out;     // copy accumulator into the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ch_ok;        // request channel is in range
      logic last_step;    // current tap pair is the outermost one
      logic pipe_busy;    // MAC pipeline still holds work
   } status_type;

endpackage

>>> sv/sfir_ctrl.sv
// Sequencing state machine for the symmetric FIR filter.
`timescale 1ns / 1ps

module sfir_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  sfir_pkg::status_type status,
   output sfir_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_RUN,
      ST_DRAIN,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd.take_sample = accept && (req_kind == sfir_pkg::KIND_SAMPLE) && status.ch_ok;
      cmd.take_coef   = accept && (req_kind == sfir_pkg::KIND_COEF);
      cmd.write       = (state_ff == ST_WRITE);
      cmd.issue       = (state_ff == ST_RUN);
      cmd.load_out    = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take_sample) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_RUN;
         ST_RUN: begin
            if (status.last_step) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (cmd.load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/sfir_dp.sv
// Delay-line memory, coefficient store and pre-add/multiply/accumulate pipeline.
`timescale 1ns / 1ps

module sfir_dp #(
   parameter int TAPS     = sfir_pkg::TAPS_DEFAULT,
   parameter int CHANNELS = sfir_pkg::CHANNELS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sfir_pkg::cmd_type                     cmd,
   output sfir_pkg::status_type                  status,
   input  logic                                  req_channel,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic        [sfir_pkg::INDEX_W-1:0]   req_coeff_index,
   input  logic signed [sfir_pkg::COEF_W-1:0]    req_coeff_value,
   output logic                                  rsp_out_channel,
   output logic signed [sfir_pkg::OUT_W-1:0]     rsp_filtered
);

   localparam int CENTER = (TAPS - 1) / 2;
   localparam int HALF   = CENTER + 1;
   localparam int DEPTH  = CHANNELS * TAPS;
   localparam int AW     = $clog2(DEPTH);
   localparam int PW     = $clog2(TAPS);
   localparam int FW     = $clog2(TAPS + 1);
   localparam int KW     = $clog2(HALF);
   localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SW     = sfir_pkg::SAMPLE_W;
   localparam int CW     = sfir_pkg::COEF_W;
   localparam int PAW    = sfir_pkg::PAIR_W;
   localparam int PRW    = sfir_pkg::PROD_W;
   localparam int OW     = sfir_pkg::OUT_W;

   // storage
   logic signed [SW-1:0] line_mem [DEPTH];
   logic signed [CW-1:0] coef_mem [HALF];
   logic [HALF-1:0]      coef_val_ff;
   logic [PW-1:0]        wp_ff   [CHANNELS];
   logic [FW-1:0]        fill_ff [CHANNELS];

   // per-item registers
   logic [CHW-1:0]       ch_ff;
   logic [AW-1:0]        base_ff;
   logic signed [SW-1:0] smp_ff;
   logic [FW-1:0]        fill_cur_ff;
   logic [KW-1:0]        k_ff;
   logic [PW-1:0]        lo_pos_ff, hi_pos_ff;

   // MAC pipeline
   logic                  v1_ff, v2_ff, v3_ff;
   logic signed [SW-1:0]  rd_lo_ff, rd_hi_ff;
   logic signed [CW-1:0]  coef_rd_ff;
   logic                  lo_ok1_ff, hi_ok1_ff, c_ok1_ff;
   logic signed [PAW-1:0] pair_ff, pair_in, lo_ext, hi_ext;
   logic signed [CW-1:0]  coef2_ff;
   logic signed [PRW-1:0] prod_ff;
   logic signed [OW-1:0]  acc_ff;
   logic signed [OW-1:0]  out_filtered_ff;
   logic                  out_channel_ff;

   logic [PW-1:0] cur_wp, new_wp, center_pos;
   logic [FW-1:0] new_fill, lo_age, hi_age;
   logic          coef_idx_ok;
   logic [KW-1:0] coef_addr;

   assign status.ch_ok     = (32'(req_channel) < CHANNELS);
   assign status.last_step = (k_ff == KW'(CENTER));
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;

   assign coef_idx_ok = (32'(req_coeff_index) < HALF);
   assign coef_addr   = KW'(req_coeff_index);

   // newest sample sits at new_wp; age a lives at new_wp - a (mod TAPS)
   always_comb begin
      cur_wp     = wp_ff[ch_ff];
      new_wp     = (cur_wp == PW'(TAPS - 1)) ? '0 : cur_wp + PW'(1);
      new_fill   = (fill_ff[ch_ff] == FW'(TAPS)) ? fill_ff[ch_ff]
                                                 : fill_ff[ch_ff] + FW'(1);
      center_pos = (new_wp >= PW'(CENTER)) ? new_wp - PW'(CENTER)
                                           : new_wp + PW'(TAPS - CENTER);
      lo_age     = FW'(CENTER) - FW'(k_ff);
      hi_age     = FW'(CENTER) + FW'(k_ff);
   end

   // item capture and tap walk
   always_ff @(posedge clock) begin
      if (cmd.take_sample) begin
         ch_ff   <= CHW'(req_channel);
         base_ff <= AW'(32'(req_channel) * TAPS);
         smp_ff  <= req_sample;
      end
      if (cmd.write) begin
         fill_cur_ff <= new_fill;
         k_ff        <= '0;
         lo_pos_ff   <= center_pos;
         hi_pos_ff   <= center_pos;
      end else if (cmd.issue) begin
         k_ff      <= k_ff + KW'(1);
         lo_pos_ff <= (lo_pos_ff == PW'(TAPS - 1)) ? '0 : lo_pos_ff + PW'(1);
         hi_pos_ff <= (hi_pos_ff == '0) ? PW'(TAPS - 1) : hi_pos_ff - PW'(1);
      end
   end

   // write pointers and fill counts; entries older than the fill count read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            wp_ff[c]   <= '0;
            fill_ff[c] <= '0;
         end
      end else if (cmd.write) begin
         wp_ff[ch_ff]   <= new_wp;
         fill_ff[ch_ff] <= new_fill;
      end
   end

   // delay-line memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         line_mem[base_ff + AW'(new_wp)] <= smp_ff;
      end
      if (cmd.issue) begin
         rd_lo_ff <= line_mem[base_ff + AW'(lo_pos_ff)];
         rd_hi_ff <= line_mem[base_ff + AW'(hi_pos_ff)];
      end
   end

   // coefficient memory
   always_ff @(posedge clock) begin
      if (cmd.take_coef && coef_idx_ok) begin
         coef_mem[coef_addr] <= req_coeff_value;
      end
      if (cmd.issue) begin
         coef_rd_ff <= coef_mem[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_val_ff <= '0;
      end else if (cmd.take_coef && coef_idx_ok) begin
         coef_val_ff[coef_addr] <= 1'b1;
      end
   end

   // stage 1 flags
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         lo_ok1_ff <= (lo_age < fill_cur_ff);
         hi_ok1_ff <= (k_ff != '0) && (hi_age < fill_cur_ff);
         c_ok1_ff  <= coef_val_ff[k_ff];
      end
   end

   // stage 2 pre-add, stage 3 multiply, stage 4 accumulate
   always_comb begin
      lo_ext  = lo_ok1_ff ? {rd_lo_ff[SW-1], rd_lo_ff} : '0;
      hi_ext  = hi_ok1_ff ? {rd_hi_ff[SW-1], rd_hi_ff} : '0;
      pair_in = lo_ext + hi_ext;
   end

   always_ff @(posedge clock) begin
      pair_ff  <= pair_in;
      coef2_ff <= c_ok1_ff ? coef_rd_ff : '0;
      prod_ff  <= coef2_ff * pair_ff;
      if (cmd.write) begin
         acc_ff <= '0;
      end else if (v3_ff) begin
         acc_ff <= acc_ff + {{(OW - PRW){prod_ff[PRW-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_filtered_ff <= acc_ff;
         out_channel_ff  <= ch_ff[0];
      end
   end

   assign rsp_filtered    = out_filtered_ff;
   assign rsp_out_channel = out_channel_ff;

endmodule

>>> sv/symmetric_fir_filter.sv
// Top level of the multi-channel symmetric (linear-phase) FIR filter.
// A sample item runs accept, WRITE, RUN (one tap pair per cycle on the shared MAC, HALF pairs,
// HALF = (TAPS+1)/2), DRAIN and OUT; OUT waits while an earlier result is stalled on rsp_stall.
// Coefficient items are accepted in IDLE and give no result. Synchronous active-high
// reset empties the delay lines via fill counts and clears coefficient valid bits at once.
`timescale 1ns / 1ps

module symmetric_fir_filter #(
   parameter int TAPS     = sfir_pkg::TAPS_DEFAULT,
   parameter int CHANNELS = sfir_pkg::CHANNELS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic                                  req_channel,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic        [sfir_pkg::INDEX_W-1:0]   req_coeff_index,
   input  logic signed [sfir_pkg::COEF_W-1:0]    req_coeff_value,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_out_channel,
   output logic signed [sfir_pkg::OUT_W-1:0]     rsp_filtered
);

   // The controller walks IDLE -> WRITE -> RUN (one tap pair per cycle) -> DRAIN -> OUT.
   // Each delay line is a circular buffer in one shared memory with two read ports, so the
   // pair x[center-k], x[center+k] is fetched together and pre-added before the multiply.
   // Samples older than a channel's fill count read as zero, matching the zeroed line.
   // The result sits in an output register; the block goes back to IDLE once it is loaded,
   // so the next item is accepted while that result still waits on rsp_stall.

   sfir_pkg::cmd_type    cmd;
   sfir_pkg::status_type status;

   sfir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfir_dp #(
      .TAPS     (TAPS),
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .rsp_out_channel (rsp_out_channel),
      .rsp_filtered    (rsp_filtered)
   );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the symmetric FIR filter: directed table, random items, predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int TAPS     = sfir_pkg::TAPS_DEFAULT;
   localparam int CHANNELS = sfir_pkg::CHANNELS_DEFAULT;
   localparam int CENTER   = (TAPS - 1) / 2;
   localparam int HALF     = CENTER + 1;

   localparam int N_DIRECTED   = 20;
   localparam int N_RANDOM     = 730;
   // Timeout guard for the whole run of directed and random items.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = HALF + 64;

   // one input item; typed/want carry a hand-written expectation for directed rows
   typedef struct {
      logic                                 kind;
      logic                                 ch;
      logic signed [sfir_pkg::SAMPLE_W-1:0] sample;
      logic [sfir_pkg::INDEX_W-1:0]         idx;
      logic signed [sfir_pkg::COEF_W-1:0]   coef;
      bit                                   typed;
      logic signed [sfir_pkg::OUT_W-1:0]    want;
   } fir_item_type;

   typedef struct {
      logic                              ch;
      logic signed [sfir_pkg::OUT_W-1:0] filtered;
   } fir_result_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_kind;
   logic                                 req_channel;
   logic signed [sfir_pkg::SAMPLE_W-1:0] req_sample;
   logic [sfir_pkg::INDEX_W-1:0]         req_coeff_index;
   logic signed [sfir_pkg::COEF_W-1:0]   req_coeff_value;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic                                 rsp_out_channel;
   logic signed [sfir_pkg::OUT_W-1:0]    rsp_filtered;

   // predictor state: per-channel delay lines (entry 0 newest) and shared half-taps
   logic signed [sfir_pkg::SAMPLE_W-1:0] line_hist [CHANNELS][TAPS];
   logic signed [sfir_pkg::COEF_W-1:0]   half_taps [HALF];

   fir_result_type pending_results [$];
   fir_result_type head;

   int n_errors      = 0;
   int n_results     = 0;
   int n_samples     = 0;
   int n_coef_writes = 0;
   int n_coef_dropped = 0;
   int burst_left    = 0;
   int cycle_count   = 0;

   symmetric_fir_filter #(
      .TAPS     (TAPS),
      .CHANNELS (CHANNELS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_filtered    (rsp_filtered)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, pending_results.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                  input logic signed [63:0] want);
      n_errors++;
      $display("MISMATCH result %0d: %s got %0d expected %0d", n_results, what, got, want);
   endtask

   // Applies one accepted item to the predictor state; gives=1 when a result is due.
   task automatic filter_step(input fir_item_type it, output bit gives,
                              output logic signed [sfir_pkg::OUT_W-1:0] value);
      longint acc;
      int     k;
      gives = 1'b0;
      value = '0;
      if (it.kind == sfir_pkg::KIND_COEF) begin
         n_coef_writes++;
         if (it.idx < HALF) half_taps[it.idx] = it.coef;
         else n_coef_dropped++;
      end else if (it.ch < CHANNELS) begin
         n_samples++;
         for (k = TAPS - 1; k > 0; k--) line_hist[it.ch][k] = line_hist[it.ch][k-1];
         line_hist[it.ch][0] = it.sample;
         acc = longint'(half_taps[0]) * longint'(line_hist[it.ch][CENTER]);
         for (k = 1; k < HALF; k++)
            acc += longint'(half_taps[k]) * (longint'(line_hist[it.ch][CENTER-k]) +
                                             longint'(line_hist[it.ch][CENTER+k]));
         gives = 1'b1;
         value = acc[sfir_pkg::OUT_W-1:0];
      end
   endtask

   // Drives one item from the falling edge and holds it until the block takes it.
   // Bursts of back-to-back items are broken by idle gaps of random length.
   task automatic send_item(input fir_item_type it);
      bit                                gives;
      logic signed [sfir_pkg::OUT_W-1:0] value;
      int                                gap;
      @(negedge clock);
      req_valid       = 1'b1;
      req_kind        = it.kind;
      req_channel     = it.ch;
      req_sample      = it.sample;
      req_coeff_index = it.idx;
      req_coeff_value = it.coef;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filter_step(it, gives, value);
      if (gives) pending_results.push_back('{it.ch, it.typed ? it.want : value});
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12);
         gap = ($urandom_range(99) < 15) ? $urandom_range(150, 20) : $urandom_range(8, 1);
         @(negedge clock);
         req_valid       = 1'b0;
         req_kind        = 1'($urandom);
         req_channel     = 1'($urandom);
         req_sample      = 16'($urandom);
         req_coeff_index = 8'($urandom);
         req_coeff_value = 18'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // result checker: oldest expectation against every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_filtered, 0);
         end else begin
            head = pending_results.pop_front();
            if (rsp_out_channel !== head.ch)
               report_mismatch("out_channel", rsp_out_channel, head.ch);
            if (rsp_filtered !== head.filtered)
               report_mismatch("filtered", rsp_filtered, head.filtered);
         end
      end
   end

   // result side: stall bursts of its own, with long stall-free stretches
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(3) == 0) begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(300, 50)) @(negedge clock);
         end else begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(30, 1)) @(negedge clock);
            rsp_stall = 1'b0;
            repeat ($urandom_range(60, 1)) @(negedge clock);
         end
      end
   end

   // stimulus
   initial begin
      fir_item_type directed [N_DIRECTED];
      fir_item_type it;
      int           i;
      int           c;
      int           loud;
      bit           polarity;

      // sample: kind, channel, sample, coeff_index, coeff_value, typed, expected filtered
      directed = '{
         // after reset every coefficient is zero
         '{sfir_pkg::KIND_SAMPLE, 1'b0, 16'sh0000, 8'd0,   18'sh00000, 1'b1, 43'sd0},
         '{sfir_pkg::KIND_SAMPLE, 1'b1, 16'sh8000, 8'hFF,  18'sh3FFFF, 1'b1, 43'sd0},
         // outermost tap at max: only x[0] pairs with it on a fresh line
         '{sfir_pkg::KIND_COEF,   1'b1, 16'sh7FFF, 8'd128, 18'sh1FFFF, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_SAMPLE, 1'b0, 16'sh7FFF, 8'd0,   18'sh00000, 1'b1, 43'sd4294803457},
         '{sfir_pkg::KIND_COEF,   1'b0, 16'sh0000, 8'd128, 18'sh20000, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_SAMPLE, 1'b1, 16'sh8000, 8'd0,   18'sh00000, 1'b1, 43'sd4294967296},
         // center tap = 1.0
         '{sfir_pkg::KIND_COEF,   1'b0, 16'sh0000, 8'd0,   18'sh10000, 1'b0, 43'sd0},
         // indexes past the last half-tap are dropped
         '{sfir_pkg::KIND_COEF,   1'b1, 16'sh1234, 8'd129, 18'sh03039, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_COEF,   1'b1, 16'shFFFF, 8'd255, 18'sh3FFFF, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_SAMPLE, 1'b0, 16'shFFFF, 8'd0,   18'sh00000, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_COEF,   1'b0, 16'sh0000, 8'd1,   18'sh3FFFF, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_COEF,   1'b0, 16'sh0000, 8'd64,  18'sh00001, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_SAMPLE, 1'b1, 16'sh5555, 8'h55,  18'sh15555, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_SAMPLE, 1'b0, 16'shAAAA, 8'hAA,  18'sh2AAAA, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_COEF,   1'b1, 16'sh0000, 8'd127, 18'sh15555, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_COEF,   1'b0, 16'sh0000, 8'd2,   18'sh2AAAA, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_SAMPLE, 1'b1, 16'sh7FFF, 8'd0,   18'sh00000, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_SAMPLE, 1'b0, 16'sh8000, 8'd0,   18'sh00000, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_COEF,   1'b0, 16'sh0000, 8'd128, 18'sh00000, 1'b0, 43'sd0},
         '{sfir_pkg::KIND_SAMPLE, 1'b1, 16'sh0001, 8'd0,   18'sh00000, 1'b0, 43'sd0}
      };

      for (c = 0; c < CHANNELS; c++)
         for (i = 0; i < TAPS; i++) line_hist[c][i] = '0;
      for (i = 0; i < HALF; i++) half_taps[i] = '0;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = sfir_pkg::KIND_SAMPLE;
      req_channel     = 1'b0;
      req_sample      = '0;
      req_coeff_index = '0;
      req_coeff_value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < N_DIRECTED; i++) send_item(directed[i]);

      // random part: mostly samples; every 60 items pick at random between ordinary content
      // and a loud stretch that drives the sum toward its widest values
      loud     = 0;
      polarity = 1'b0;
      for (i = 0; i < N_RANDOM; i++) begin
         if (i % 60 == 0) begin
            loud     = ($urandom_range(2) == 0);
            polarity = 1'($urandom);
         end
         it.kind   = ($urandom_range(99) < 80) ? sfir_pkg::KIND_SAMPLE : sfir_pkg::KIND_COEF;
         it.ch     = 1'($urandom);
         it.typed  = 1'b0;
         it.want   = '0;
         it.idx    = ($urandom_range(99) < 85) ? 8'($urandom_range(HALF - 1)) : 8'($urandom);
         if (loud) begin
            it.sample = (($urandom_range(9) == 0) ^ polarity) ? 16'sh8000 : 16'sh7FFF;
            it.coef   = ($urandom_range(9) == 0) ? 18'sh20000 : 18'sh1FFFF;
         end else begin
            c = $urandom_range(9);
            it.sample = (c == 0) ? 16'sh7FFF : (c == 1) ? 16'sh8000 : 16'($urandom);
            c = $urandom_range(9);
            it.coef   = (c == 0) ? 18'sh1FFFF : (c == 1) ? 18'sh20000 :
                        (c == 2) ? 18'sh00000 : 18'($urandom);
         end
         send_item(it);
      end

      @(negedge clock);
      req_valid = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d samples over %0d channels and %0d coefficient writes (%0d dropped)",
               n_samples, CHANNELS, n_coef_writes, n_coef_dropped);
      $display("checked %0d results in %0d cycles, %0d mismatches", n_results, cycle_count,
               n_errors);
      if (n_errors == 0 && pending_results.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
